// ===== hdl/sha1_message_digest_core_defines.svh =====
// Assertion macros used by the digest core to check its own logic.
`ifndef SHA1_MESSAGE_DIGEST_CORE_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("smd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SMD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("smd assertion failed");

`endif

// ===== hdl/smd_pkg.sv =====
`default_nettype none

package smd_pkg;

    localparam int WORD_W     = 32;
    localparam int HASH_WORDS = 5;
    localparam int WIN_DEPTH  = 16;
    localparam int WIN_AW     = 4;
    localparam int ROUNDS     = 80;
    localparam int ROUND_W    = 7;
    localparam int COUNT_W    = 61;
    localparam int IDX_W      = 3;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t [HASH_WORDS-1:0] vars_t;

    localparam vars_t INIT_HASH = {
        32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
    };

    localparam word_t K_0 = 32'h5a827999;
    localparam word_t K_1 = 32'h6ed9eba1;
    localparam word_t K_2 = 32'h8f1bbcdc;
    localparam word_t K_3 = 32'hca62c1d6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic word_t rotl(input word_t x, input int n);
        rotl = (x << n) | (x >> (WORD_W - n));
    endfunction

endpackage

`default_nettype wire

// ===== hdl/smd_ram.sv =====
`default_nettype none

module smd_ram #(
    parameter int WIDTH = smd_pkg::WORD_W,
    parameter int DEPTH = smd_pkg::WIN_DEPTH
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== hdl/smd_round.sv =====
`default_nettype none

module smd_round (
    input  wire smd_pkg::vars_t                     vars,
    input  wire smd_pkg::word_t                     w,
    input  wire logic [smd_pkg::ROUND_W-1:0]        round_num,
    output smd_pkg::vars_t                          vars_next
);

    always_comb begin
        smd_pkg::word_t f;
        smd_pkg::word_t k;
        smd_pkg::word_t tmp;
        if (round_num inside {[7'd0:7'd19]}) begin
            f = (vars[1] & vars[2]) | (~vars[1] & vars[3]);
            k = smd_pkg::K_0;
        end else if (round_num inside {[7'd20:7'd39]}) begin
            f = vars[1] ^ vars[2] ^ vars[3];
            k = smd_pkg::K_1;
        end else if (round_num inside {[7'd40:7'd59]}) begin
            f = (vars[1] & vars[2]) | (vars[1] & vars[3]) | (vars[2] & vars[3]);
            k = smd_pkg::K_2;
        end else begin
            f = vars[1] ^ vars[2] ^ vars[3];
            k = smd_pkg::K_3;
        end
        tmp = smd_pkg::rotl(vars[0], 5) + f + vars[4] + w + k;
        vars_next[4] = vars[3];
        vars_next[3] = vars[2];
        vars_next[2] = smd_pkg::rotl(vars[1], 30);
        vars_next[1] = vars[0];
        vars_next[0] = tmp;
    end

endmodule

`default_nettype wire

// ===== hdl/sha1_message_digest_core.sv =====
// SHA-1 digest core, one message byte per input beat.
// Input channel s_*: s_msg_byte with s_has_byte marks a message byte; s_end_of_msg marks
// the last beat of a message (with or without a byte). A beat with neither flag is
// accepted and ignored. An empty message is a beat with only s_end_of_msg set.
// Output channel m_*: five beats per message, digest word 0 first, m_last_word on word 4.
// Byte beats are taken back to back while s_ready is high; every 64th byte starts
// a block compression (a read-priming step, 80 rounds at one per cycle through the
// round unit, one chain update), during which s_ready is low. The message schedule
// lives in four mirrored 16x32 RAMs so that each round reads its four taps at once.
// Message end: the marker word and the rest of the padding are written one word per
// cycle and one or two compressions run, then the digest buffer is loaded; s_ready
// stays low throughout.
// The digest sits in its own buffer, so the next message streams in while the receiver
// stalls; only the load of the following digest waits for the buffer to drain.
// Reset (aresetn low, synchronous) restores the initial hash, clears the byte count and
// drops any pending output beats. The core also restores the hash and count after each digest.
`default_nettype none

module sha1_message_digest_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_msg_byte,
    input  wire logic        s_has_byte,
    input  wire logic        s_end_of_msg,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_digest_word,
    output logic [2:0]       m_word_index,
    output logic             m_last_word
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PADW = 3'd1;
    localparam logic [2:0] S_FILL = 3'd2;
    localparam logic [2:0] S_PRE  = 3'd3;
    localparam logic [2:0] S_CRND = 3'd4;
    localparam logic [2:0] S_CFIN = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    localparam int AW = smd_pkg::WIN_AW;
    localparam int RW = smd_pkg::ROUND_W;
    localparam int CW = smd_pkg::COUNT_W;
    localparam int IW = smd_pkg::IDX_W;

    localparam logic [RW-1:0] LAST_ROUND = RW'(smd_pkg::ROUNDS - 1);
    localparam logic [RW-1:0] WIN_ROUNDS = RW'(smd_pkg::WIN_DEPTH);
    localparam logic [IW-1:0] LAST_IDX   = IW'(smd_pkg::HASH_WORDS - 1);
    localparam logic [AW-1:0] LAST_WORD  = AW'(smd_pkg::WIN_DEPTH - 1);
    localparam logic [AW-1:0] LEN_HI_IDX = AW'(smd_pkg::WIN_DEPTH - 2);

    logic [2:0]      state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [RW-1:0]   round_reg, round_next;
    logic [AW-1:0]   widx_reg, widx_next;
    logic            end_pend_reg, end_pend_next;
    logic            padded_reg, padded_next;
    logic            extra_reg, extra_next;
    smd_pkg::word_t  pack_reg, pack_next;
    smd_pkg::vars_t  chain_reg, chain_next;
    smd_pkg::vars_t  vars_reg, vars_next;
    smd_pkg::vars_t  obuf_reg, obuf_next;
    logic            obusy_reg, obusy_next;
    logic [IW-1:0]   oidx_reg, oidx_next;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    smd_pkg::word_t  wr_data;
    logic [RW-1:0]   rd_round;
    logic [AW-1:0]   rd_addr [4];
    smd_pkg::word_t  rd_data [4];
    smd_pkg::word_t  sched_w;
    smd_pkg::vars_t  round_out;
    smd_pkg::word_t  pad_word;
    smd_pkg::word_t  fill_word;
    logic [5:0]      pos;
    logic            s_fire;
    logic            m_fire;

    assign s_ready       = (state_reg == S_IDLE);
    assign s_fire        = s_valid && s_ready;
    assign m_valid       = obusy_reg;
    assign m_fire        = m_valid && m_ready;
    assign m_digest_word = obuf_reg[oidx_reg];
    assign m_word_index  = oidx_reg;
    assign m_last_word   = (oidx_reg == LAST_IDX);
    assign pos           = count_reg[5:0];

    // Read taps for round r are r, r-3, r-8, r-14 modulo 16; issue them in the cycle before.
    assign rd_round   = (state_reg == S_CRND) ? (round_reg + RW'(1)) : '0;
    assign rd_addr[0] = rd_round[AW-1:0];
    assign rd_addr[1] = rd_round[AW-1:0] - AW'(3);
    assign rd_addr[2] = rd_round[AW-1:0] - AW'(8);
    assign rd_addr[3] = rd_round[AW-1:0] - AW'(14);

    for (genvar i = 0; i < 4; i++) begin : g_win
        smd_ram #(
            .WIDTH (smd_pkg::WORD_W),
            .DEPTH (smd_pkg::WIN_DEPTH)
        ) u_win (
            .aclk    (aclk),
            .wr_en   (wr_en),
            .wr_addr (wr_addr),
            .wr_data (wr_data),
            .rd_addr (rd_addr[i]),
            .rd_data (rd_data[i])
        );
    end

    assign sched_w = (round_reg < WIN_ROUNDS) ? rd_data[0]
                   : smd_pkg::rotl(rd_data[0] ^ rd_data[1] ^ rd_data[2] ^ rd_data[3], 1);

    smd_round u_round (
        .vars      (vars_reg),
        .w         (sched_w),
        .round_num (round_reg),
        .vars_next (round_out)
    );

    // First padding word: bytes taken so far, then the marker byte, then zeros.
    always_comb begin
        case (pos[1:0])
            2'd0:    pad_word = {smd_pkg::PAD_BYTE, 24'd0};
            2'd1:    pad_word = {pack_reg[31:24], smd_pkg::PAD_BYTE, 16'd0};
            2'd2:    pad_word = {pack_reg[31:16], smd_pkg::PAD_BYTE, 8'd0};
            default: pad_word = {pack_reg[31:8], smd_pkg::PAD_BYTE};
        endcase
    end

    always_comb begin
        if (!extra_reg && widx_reg == LEN_HI_IDX) begin
            fill_word = count_reg[CW-1:CW-32];
        end else if (!extra_reg && widx_reg == LAST_WORD) begin
            fill_word = {count_reg[CW-33:0], 3'd0};
        end else begin
            fill_word = '0;
        end
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        round_next    = round_reg;
        widx_next     = widx_reg;
        end_pend_next = end_pend_reg;
        padded_next   = padded_reg;
        extra_next    = extra_reg;
        pack_next     = pack_reg;
        chain_next    = chain_reg;
        vars_next     = vars_reg;
        obuf_next     = obuf_reg;
        obusy_next    = obusy_reg;
        oidx_next     = oidx_reg;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = '0;

        if (m_fire) begin
            if (oidx_reg == LAST_IDX) begin
                obusy_next = 1'b0;
                oidx_next  = '0;
            end else begin
                oidx_next = oidx_reg + IW'(1);
            end
        end

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    if (s_has_byte) begin
                        case (pos[1:0])
                            2'd0:    pack_next = {s_msg_byte, 24'd0};
                            2'd1:    pack_next = {pack_reg[31:24], s_msg_byte, 16'd0};
                            2'd2:    pack_next = {pack_reg[31:16], s_msg_byte, 8'd0};
                            default: pack_next = {pack_reg[31:8], s_msg_byte};
                        endcase
                        if (pos[1:0] == 2'd3) begin
                            wr_en   = 1'b1;
                            wr_addr = pos[5:2];
                            wr_data = pack_next;
                        end
                        count_next = count_reg + CW'(1);
                    end
                    end_pend_next = s_end_of_msg;
                    if (s_has_byte && pos == 6'd63) begin
                        state_next = S_PRE;
                    end else if (s_end_of_msg) begin
                        state_next = S_PADW;
                    end
                end
            end
            S_PADW: begin
                wr_en       = 1'b1;
                wr_addr     = pos[5:2];
                wr_data     = pad_word;
                padded_next = 1'b1;
                // No room for the length in this block: pad out and add one more.
                extra_next  = (pos[5:3] == 3'b111);
                if (pos[5:2] == LAST_WORD) begin
                    state_next = S_PRE;
                end else begin
                    widx_next  = pos[5:2] + AW'(1);
                    state_next = S_FILL;
                end
            end
            S_FILL: begin
                wr_en   = 1'b1;
                wr_addr = widx_reg;
                wr_data = fill_word;
                if (widx_reg == LAST_WORD) begin
                    state_next = S_PRE;
                end else begin
                    widx_next = widx_reg + AW'(1);
                end
            end
            S_PRE: begin
                vars_next  = chain_reg;
                round_next = '0;
                state_next = S_CRND;
            end
            S_CRND: begin
                vars_next = round_out;
                if (round_reg >= WIN_ROUNDS) begin
                    wr_en   = 1'b1;
                    wr_addr = round_reg[AW-1:0];
                    wr_data = sched_w;
                end
                if (round_reg == LAST_ROUND) begin
                    round_next = '0;
                    state_next = S_CFIN;
                end else begin
                    round_next = round_reg + RW'(1);
                end
            end
            S_CFIN: begin
                for (int i = 0; i < smd_pkg::HASH_WORDS; i++) begin
                    chain_next[i] = chain_reg[i] + vars_reg[i];
                end
                if (!end_pend_reg) begin
                    state_next = S_IDLE;
                end else if (!padded_reg) begin
                    state_next = S_PADW;
                end else if (extra_reg) begin
                    extra_next = 1'b0;
                    widx_next  = '0;
                    state_next = S_FILL;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // Hold the digest until the output buffer has drained.
                if (!obusy_reg) begin
                    obuf_next     = chain_reg;
                    obusy_next    = 1'b1;
                    oidx_next     = '0;
                    chain_next    = smd_pkg::INIT_HASH;
                    vars_next     = '0;
                    count_next    = '0;
                    end_pend_next = 1'b0;
                    padded_next   = 1'b0;
                    extra_next    = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            round_reg    <= '0;
            widx_reg     <= '0;
            end_pend_reg <= 1'b0;
            padded_reg   <= 1'b0;
            extra_reg    <= 1'b0;
            chain_reg    <= smd_pkg::INIT_HASH;
            vars_reg     <= '0;
            obusy_reg    <= 1'b0;
            oidx_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            round_reg    <= round_next;
            widx_reg     <= widx_next;
            end_pend_reg <= end_pend_next;
            padded_reg   <= padded_next;
            extra_reg    <= extra_next;
            chain_reg    <= chain_next;
            vars_reg     <= vars_next;
            obusy_reg    <= obusy_next;
            oidx_reg     <= oidx_next;
        end
    end

    always_ff @(posedge aclk) begin
        pack_reg <= pack_next;
        obuf_reg <= obuf_next;
    end

`include "sha1_message_digest_core_defines.svh"

    `SMD_ASSERT_NEXT(a_last_round_ends,
        (state_reg == S_CRND && round_reg == LAST_ROUND),
        (state_reg == S_CFIN && round_reg == '0))
    `SMD_ASSERT_NEXT(a_drain_done, (m_fire && m_last_word), (!m_valid))
    `SMD_ASSERT_NEXT(a_digest_load, (state_reg == S_DONE && !obusy_reg),
        (m_valid && m_word_index == '0 && count_reg == '0 && state_reg == S_IDLE))
    `SMD_ASSERT_NOW(a_round_range, (state_reg != S_CRND), (round_reg == '0))

endmodule

`default_nettype wire

// ===== tb/sv/sha1_digest_scoreboard_pkg.sv =====
package sha1_digest_scoreboard_pkg;

    typedef logic [smd_pkg::COUNT_W-1:0] count_t;

    typedef struct packed {
        smd_pkg::word_t word;
        logic [2:0]     index;
        logic           last;
    } digest_beat_t;

    class digest_scoreboard;

        smd_pkg::word_t     chain[smd_pkg::HASH_WORDS];
        smd_pkg::word_t     sched[smd_pkg::WIN_DEPTH];
        count_t             nbytes;
        digest_beat_t       digest_words_due[$];
        int                 errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            chain[0] = 32'h67452301;
            chain[1] = 32'hefcdab89;
            chain[2] = 32'h98badcfe;
            chain[3] = 32'h10325476;
            chain[4] = 32'hc3d2e1f0;
            nbytes   = '0;
        endfunction

        // Big-endian packing: byte 0 of a word lands in bits 31:24.
        function void place_byte(int pos, logic [7:0] b);
            if ((pos & 3) == 0) begin
                sched[pos >> 2] = '0;
            end
            sched[pos >> 2][31 - 8 * (pos & 3) -: 8] = b;
        endfunction

        function void compress();
            smd_pkg::word_t a, b, c, d, e, f, k, w, t;
            int r;
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            e = chain[4];
            for (r = 0; r < 80; r++) begin
                if (r < 16) begin
                    w = sched[r];
                end else begin
                    w = sched[(r - 3) & 15] ^ sched[(r - 8) & 15] ^
                        sched[(r - 14) & 15] ^ sched[r & 15];
                    w = {w[30:0], w[31]};
                    sched[r & 15] = w;
                end
                if (r < 20) begin
                    f = (b & c) | (~b & d);
                    k = 32'h5a827999;
                end else if (r < 40) begin
                    f = b ^ c ^ d;
                    k = 32'h6ed9eba1;
                end else if (r < 60) begin
                    f = (b & c) | (b & d) | (c & d);
                    k = 32'h8f1bbcdc;
                end else begin
                    f = b ^ c ^ d;
                    k = 32'hca62c1d6;
                end
                t = {a[26:0], a[31:27]} + f + e + w + k;
                e = d;
                d = c;
                c = {b[1:0], b[31:2]};
                b = a;
                a = t;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
            chain[4] += e;
        endfunction

        function void absorb_beat(logic [7:0] b, logic has_byte, logic eom);
            logic [63:0]  nbits;
            digest_beat_t beat;
            int           pos;
            int           p;
            if (has_byte) begin
                pos = int'(nbytes[5:0]);
                place_byte(pos, b);
                nbytes = nbytes + count_t'(1);
                if (pos == 63) begin
                    compress();
                end
            end
            if (!eom) begin
                return;
            end
            nbits = {nbytes, 3'b000};
            pos   = int'(nbytes[5:0]);
            place_byte(pos, 8'h80);
            for (p = pos + 1; p < 64; p++) begin
                place_byte(p, 8'h00);
            end
            // No room for the length field: flush this block, length goes in a fresh one.
            if (pos >= 56) begin
                compress();
                foreach (sched[j]) begin
                    sched[j] = '0;
                end
            end
            sched[14] = nbits[63:32];
            sched[15] = nbits[31:0];
            compress();
            for (p = 0; p < smd_pkg::HASH_WORDS; p++) begin
                beat.word  = chain[p];
                beat.index = 3'(p);
                beat.last  = (p == smd_pkg::HASH_WORDS - 1);
                digest_words_due.push_back(beat);
            end
            restart();
        endfunction

        task report(string line);
            $display("tb: mismatch: %s", line);
            errors++;
        endtask

        task check_digest_word(smd_pkg::word_t word, logic [2:0] index, logic last);
            digest_beat_t want;
            if (digest_words_due.size() == 0) begin
                report($sformatf("unexpected digest word %h index %0d", word, index));
                return;
            end
            want = digest_words_due.pop_front();
            if (word !== want.word) begin
                report($sformatf("digest word %0d got %h want %h", want.index, word,
                                 want.word));
            end
            if (index !== want.index) begin
                report($sformatf("word index got %0d want %0d", index, want.index));
            end
            if (last !== want.last) begin
                report($sformatf("last word flag got %b want %b at index %0d", last,
                                 want.last, want.index));
            end
        endtask

    endclass

endpackage

// ===== tb/sv/sha1_message_digest_core_tb.sv =====
module sha1_message_digest_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 1500;
    localparam int ITEM_TARGET = 270;

    logic        aclk;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [7:0]  s_msg_byte   = 8'h00;
    logic        s_has_byte   = 1'b0;
    logic        s_end_of_msg = 1'b0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [31:0] m_digest_word;
    logic [2:0]  m_word_index;
    logic        m_last_word;

    sha1_digest_scoreboard_pkg::digest_scoreboard sb;
    bit  quiet         = 1'b0;
    bit  tx_calm       = 1'b0;
    bit  long_hold_req = 1'b0;
    int  cycle_count   = 0;
    int  items_sent    = 0;

    sha1_message_digest_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_msg_byte    (s_msg_byte),
        .s_has_byte    (s_has_byte),
        .s_end_of_msg  (s_end_of_msg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_last_word   (m_last_word)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    initial sb = new();

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.absorb_beat(s_msg_byte, s_has_byte, s_end_of_msg);
            end
            if (m_valid && m_ready) begin
                sb.check_digest_word(m_digest_word, m_word_index, m_last_word);
            end
        end
    end

    // Result side: random short stalls, calm windows, and one long hold on request.
    initial begin : receiver
        int hold_left;
        int calm_left;
        bit calm;
        hold_left = 0;
        calm_left = 0;
        calm      = 1'b0;
        forever begin
            @(negedge aclk);
            if (calm_left == 0) begin
                calm      = ($urandom_range(0, 2) == 0);
                calm_left = 64;
            end
            calm_left--;
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end else if (hold_left == 0 && !calm && !quiet && $urandom_range(0, 5) == 0) begin
                hold_left = int'($urandom_range(1, 4));
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Call at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(input logic [7:0] b, input logic has_byte, input logic eom);
        int gap;
        if (!quiet && !tx_calm && $urandom_range(0, 3) == 0) begin
            gap = int'($urandom_range(1, 4));
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_msg_byte   <= b;
        s_has_byte   <= has_byte;
        s_end_of_msg <= eom;
        do @(posedge aclk); while (!(s_valid && s_ready));
        items_sent++;
        @(negedge aclk);
    endtask

    initial begin : stimulus
        int len;
        int i;
        int pick;
        bit end_apart;
        bit eom;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Empty message, then an idle beat that must be ignored.
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'h5a, 1'b0, 1'b0);
        // One-byte message ending on its own byte.
        send_beat(8'hff, 1'b1, 1'b1);
        // Byte, then a bare end beat carrying a stray byte.
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'ha5, 1'b0, 1'b1);
        // "abc"
        send_beat(8'h61, 1'b1, 1'b0);
        send_beat(8'h62, 1'b1, 1'b0);
        send_beat(8'h63, 1'b1, 1'b1);
        // Empty message with garbage on the byte lanes, then a two-byte message with an idle beat.
        send_beat(8'hff, 1'b0, 1'b1);
        send_beat(8'h80, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'h7f, 1'b1, 1'b1);

        // Hold the result side while messages keep coming, to back up the core.
        long_hold_req = 1'b1;
        while (items_sent < ITEM_TARGET) begin
            tx_calm = ($urandom_range(0, 3) == 0);
            pick    = $urandom_range(0, 9);
            if (pick < 6) begin
                len = $urandom_range(0, 8);
            end else if (pick < 8) begin
                len = $urandom_range(9, 40);
            end else begin
                case ($urandom_range(0, 3))
                    0: len = 55;
                    1: len = 56;
                    2: len = 63;
                    default: len = 64;
                endcase
            end
            end_apart = (len == 0) || ($urandom_range(0, 1) == 1);
            for (i = 0; i < len; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                end
                eom = (i == len - 1) && !end_apart;
                send_beat(8'($urandom_range(0, 255)), 1'b1, eom);
            end
            if (end_apart) begin
                send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            end
            if (items_sent > ITEM_TARGET - 60) begin
                quiet = 1'b1;
            end
        end
        s_valid <= 1'b0;

        while (sb.digest_words_due.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (sb.errors == 0 && sb.digest_words_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/smd_pkg.sv
hdl/smd_ram.sv
hdl/smd_round.sv
hdl/sha1_message_digest_core.sv
tb/sv/sha1_digest_scoreboard_pkg.sv
tb/sv/sha1_message_digest_core_tb.sv
